### design/svhm_pkg.sv
package svhm_pkg;

    localparam int NUM_SENSORS_DEF = 16;
    localparam int WINDOW_DEF      = 10;

    localparam int SAMPLE_W = 16;
    localparam int CONF_W   = 16;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 8;
    localparam int FRAC_SH  = 40;

    localparam logic [17:0] EPS_Q24 = 18'd167772;

    localparam logic [15:0] UNRELIABLE_RST = 16'd39322;
    localparam logic [15:0] FAIL_RST       = 16'd19661;
    localparam logic [7:0]  LIMIT_RST      = 8'd6;

    localparam int CFG_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_UNRELIABLE = 2'd0,
        REG_FAIL       = 2'd1,
        REG_LIMIT      = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_UNRELIABLE = 2'd1,
        ST_FAILED     = 2'd2
    } t_status;

endpackage

### design/svhm_div.sv
module svhm_div #(
    parameter int NUMW = 52,
    parameter int DENW = 51
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [NUMW-1:0]             i_num,
    input  logic [DENW-1:0]             i_den,
    output logic                        o_done,
    output logic [svhm_pkg::CONF_W-1:0] o_quot
);
    import svhm_pkg::*;

    localparam int RW = (DENW + CONF_W > NUMW) ? DENW + CONF_W : NUMW;
    localparam int KW = $clog2(CONF_W + 1);

    logic [RW-1:0]     r_rem;
    logic [RW-1:0]     r_dsh;
    logic [CONF_W-1:0] r_q;
    logic [KW-1:0]     r_k;
    logic              r_busy;
    logic              r_done;
    logic [CONF_W-1:0] r_quot;
    logic              ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if ((ge && r_k == KW'(CONF_W)) || r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= RW'(i_num);
            r_dsh <= RW'({i_den, {CONF_W{1'b0}}});
            r_q   <= '0;
            r_k   <= KW'(CONF_W);
        end else if (r_busy) begin
            if (ge && r_k == KW'(CONF_W)) begin
                r_quot <= '1;
            end else begin
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[CONF_W-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_k   <= r_k - 1'b1;
                if (r_k == '0) begin
                    r_quot <= {r_q[CONF_W-2:0], ge};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### design/sensor_variance_health_monitor_top.sv
// Sensor health monitor. Each accepted sample is pushed into its sensor's ring of the last
// WINDOW samples; the population variance of the ring yields a Q0.16 confidence,
// min(1, 1/(variance/2^24 + 0.01)), compared against the unreliable and fail thresholds
// to give a status and to feed a saturating global failure count that latches fallback at
// the failure limit. Only one sample is in work at a time. For a sensor holding at least
// two samples, the bulk of the work is the 17-step restoring divider (one quotient bit per
// cycle), which follows the reads of the per-sensor state memory and the sample memory.
// When the quotient saturates, the divider stops after its first step. A sensor holding
// fewer than two samples skips the division. A sensor index at or above NUM_SENSORS goes
// straight from S_IDLE to S_FIN. The next sample is taken in the cycle after a result is
// loaded. The next sample is taken while a finished result still waits at the output, and
// that sample then waits in its last step until the output register is free.
module sensor_variance_health_monitor_top #(
    parameter int NUM_SENSORS = svhm_pkg::NUM_SENSORS_DEF,
    parameter int WINDOW      = svhm_pkg::WINDOW_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [svhm_pkg::INDEX_W-1:0]      i_sensor_index,
    input  logic [svhm_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [svhm_pkg::INDEX_W-1:0]      o_sensor_echo,
    output logic [svhm_pkg::CONF_W-1:0]       o_confidence,
    output logic [1:0]                        o_status,
    output logic [svhm_pkg::COUNT_W-1:0]      o_failure_total,
    output logic                              o_fallback,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [svhm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import svhm_pkg::*;

    localparam int CW    = $clog2(WINDOW + 1);
    localparam int SLW   = $clog2(WINDOW);
    localparam int SW    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int DEPTH = NUM_SENSORS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUMW  = SAMPLE_W + CW;
    localparam int SQW   = 2 * SAMPLE_W + CW;
    localparam int VW    = SQW + CW;
    localparam int NNW   = 2 * CW;
    localparam int DENW  = VW + 1;
    localparam int NUMW  = NNW + FRAC_SH;

    typedef struct packed {
        logic [CW-1:0]   fill;
        logic [SLW-1:0]  slot;
        logic [SUMW-1:0] sum;
        logic [SQW-1:0]  sq;
    } t_sstate;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RDST   = 8'b0000_0010,
        S_RDWIN  = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_EPS    = 8'b0001_0000,
        S_LAUNCH = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_fsm;

    t_fsm r_state;

    logic [15:0] r_thr_u;
    logic [15:0] r_thr_f;
    logic [7:0]  r_limit;

    t_sstate              r_st_mem [NUM_SENSORS];
    t_sstate              r_st_rd;
    logic [NUM_SENSORS-1:0] r_st_valid;
    logic [SAMPLE_W-1:0]  r_win_mem [DEPTH];
    logic [SAMPLE_W-1:0]  r_win_rd;

    logic [SW-1:0]        r_s;
    logic [INDEX_W-1:0]   r_idx;
    logic [SAMPLE_W-1:0]  r_smp;
    logic                 r_skip;
    logic [CW-1:0]        r_fill;
    logic [SLW-1:0]       r_slot;
    logic [SUMW-1:0]      r_sum;
    logic [SQW-1:0]       r_sq;
    logic [AW-1:0]        r_waddr;
    logic [VW-1:0]        r_nq;
    logic [VW-1:0]        r_ss;
    logic [NNW-1:0]       r_nn;
    logic [DENW-1:0]      r_den;
    logic [NUMW-1:0]      r_num;
    logic [CONF_W-1:0]    r_conf;
    logic [COUNT_W-1:0]   r_fcount;
    logic                 r_fb;

    logic                 r_ovalid;
    logic [INDEX_W-1:0]   r_o_idx;
    logic [CONF_W-1:0]    r_o_conf;
    logic [1:0]           r_o_status;

    logic                 div_done;
    logic [CONF_W-1:0]    div_quot;

    logic                 in_acc;
    logic                 cfg_wr;
    logic                 out_free;
    t_sstate              cur_st;
    logic [SLW-1:0]       cur_slot;
    logic                 full;
    logic [2*SAMPLE_W-1:0] old_sq;
    logic [2*SAMPLE_W-1:0] new_sq;
    logic [SUMW-1:0]      n_sum;
    logic [SQW-1:0]       n_sq;
    logic [CW-1:0]        n_fill;
    logic [SLW-1:0]       n_slot;
    logic                 is_unr;
    logic                 is_fail;
    t_status              n_status;
    logic [1:0]           add;
    logic [COUNT_W:0]     total;
    logic [COUNT_W-1:0]   n_fcount;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_ovalid || !i_out_stall;
    assign pready   = 1'b1;

    assign cur_st   = r_st_valid[r_s] ? r_st_rd : '0;
    assign cur_slot = (int'(cur_st.slot) >= WINDOW) ? '0 : cur_st.slot;

    assign full   = (int'(r_fill) >= WINDOW);
    assign old_sq = r_win_rd * r_win_rd;
    assign new_sq = r_smp * r_smp;
    assign n_sum  = full ? r_sum - SUMW'(r_win_rd) + SUMW'(r_smp) : r_sum + SUMW'(r_smp);
    assign n_sq   = full ? r_sq - SQW'(old_sq) + SQW'(new_sq) : r_sq + SQW'(new_sq);
    assign n_fill = full ? r_fill : r_fill + 1'b1;
    assign n_slot = ({1'b0, r_slot} + 1'b1 == (SLW+1)'(WINDOW)) ? '0 : r_slot + 1'b1;

    assign is_unr  = (r_conf < r_thr_u);
    assign is_fail = (r_conf < r_thr_f);

    always_comb begin
        n_status = ST_OK;
        add      = 2'd0;
        if (is_unr) begin
            n_status = ST_UNRELIABLE;
            add      = 2'd1;
        end
        if (is_fail) begin
            n_status = ST_FAILED;
            add      = add + 2'd2;
        end
        total    = {1'b0, r_fcount} + (COUNT_W+1)'(add);
        n_fcount = total[COUNT_W] ? '1 : total[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_u <= UNRELIABLE_RST;
            r_thr_f <= FAIL_RST;
            r_limit <= LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_UNRELIABLE: r_thr_u <= pwdata[15:0];
                REG_FAIL:       r_thr_f <= pwdata[15:0];
                REG_LIMIT:      r_limit <= pwdata[7:0];
                REG_NONE:       ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_UNRELIABLE: prdata = {16'h0, r_thr_u};
            REG_FAIL:       prdata = {16'h0, r_thr_f};
            REG_LIMIT:      prdata = {24'h0, r_limit};
            REG_NONE:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_st_rd <= r_st_mem[SW'(i_sensor_index)];
        end
        if (r_state == S_RDWIN) begin
            r_st_mem[r_s] <= '{fill: n_fill, slot: n_slot, sum: n_sum, sq: n_sq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RDST) begin
            r_win_rd <= r_win_mem[AW'(int'(r_s) * WINDOW + int'(cur_slot))];
        end
        if (r_state == S_RDWIN) begin
            r_win_mem[r_waddr] <= r_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_st_valid <= '0;
            r_fcount   <= '0;
            r_fb       <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= (int'(i_sensor_index) < NUM_SENSORS) ? S_RDST : S_FIN;
                    end
                end
                S_RDST:   r_state <= S_RDWIN;
                S_RDWIN: begin
                    r_state       <= S_MUL;
                    r_st_valid[r_s] <= 1'b1;
                end
                S_MUL:    r_state <= (r_fill < CW'(2)) ? S_FIN : S_EPS;
                S_EPS:    r_state <= S_LAUNCH;
                S_LAUNCH: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state  <= S_IDLE;
                        r_ovalid <= 1'b1;
                        if (!r_skip) begin
                            r_fcount <= n_fcount;
                            if (n_fcount >= r_limit) begin
                                r_fb <= 1'b1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_idx  <= i_sensor_index;
                r_s    <= SW'(i_sensor_index);
                r_smp  <= i_sample;
                r_skip <= !(int'(i_sensor_index) < NUM_SENSORS);
                r_conf <= '1;
            end
            S_RDST: begin
                r_fill  <= cur_st.fill;
                r_slot  <= cur_slot;
                r_sum   <= cur_st.sum;
                r_sq    <= cur_st.sq;
                r_waddr <= AW'(int'(r_s) * WINDOW + int'(cur_slot));
            end
            S_RDWIN: begin
                r_fill <= n_fill;
                r_sum  <= n_sum;
                r_sq   <= n_sq;
            end
            S_MUL: begin
                r_nq <= VW'(r_fill) * VW'(r_sq);
                r_ss <= VW'(r_sum) * VW'(r_sum);
                r_nn <= NNW'(r_fill) * NNW'(r_fill);
            end
            S_EPS: begin
                r_den <= DENW'(r_nq - r_ss) + DENW'(r_nn) * DENW'(EPS_Q24);
                r_num <= {r_nn, {FRAC_SH{1'b0}}};
            end
            S_LAUNCH: ;
            S_DIV: begin
                if (div_done) begin
                    r_conf <= div_quot;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    r_o_idx    <= r_idx;
                    r_o_conf   <= r_conf;
                    r_o_status <= r_skip ? ST_OK : n_status;
                end
            end
            default: ;
        endcase
    end

    svhm_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LAUNCH),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_sensor_echo   = r_o_idx;
    assign o_confidence    = r_o_conf;
    assign o_status        = r_o_status;
    assign o_failure_total = r_fcount;
    assign o_fallback      = r_fb;

endmodule

### test/sensor_variance_health_monitor_top_test.sv
module sensor_variance_health_monitor_top_test;
    import svhm_pkg::*;

    localparam int NSENS = NUM_SENSORS_DEF;
    localparam int WIN   = WINDOW_DEF;

    typedef struct packed {
        logic [INDEX_W-1:0]  sensor;
        logic [CONF_W-1:0]   conf;
        t_status             status;
        logic [COUNT_W-1:0]  total;
        logic                fallback;
    } t_health;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [INDEX_W-1:0]    i_sensor_index = '0;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [INDEX_W-1:0]    o_sensor_echo;
    logic [CONF_W-1:0]     o_confidence;
    logic [1:0]            o_status;
    logic [COUNT_W-1:0]    o_failure_total;
    logic                  o_fallback;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    sensor_variance_health_monitor_top u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state.
    logic [15:0] ring [NSENS][WIN];
    int unsigned fill [NSENS];
    int unsigned slot [NSENS];
    longint unsigned run_sum [NSENS];
    longint unsigned run_sq [NSENS];
    int unsigned fail_count;
    bit          fallback_on;
    logic [15:0] thr_unrel;
    logic [15:0] thr_fail;
    logic [7:0]  limit;

    t_health expected_health[$];
    int errors = 0;
    int long_hold = 0;
    bit out_random = 1'b1;
    bit in_random = 1'b1;

    task automatic clear_predictor();
        for (int s = 0; s < NSENS; s++) begin
            fill[s] = 0;
            slot[s] = 0;
            run_sum[s] = 0;
            run_sq[s] = 0;
        end
        fail_count = 0;
        fallback_on = 1'b0;
        thr_unrel = UNRELIABLE_RST;
        thr_fail = FAIL_RST;
        limit = LIMIT_RST;
    endtask

    function automatic t_health predict_health(logic [3:0] s, logic [15:0] v);
        t_health h;
        longint unsigned n, sum, var_n, nn, den, q, old;
        int unsigned add;
        h.sensor = s;
        h.conf = 16'hFFFF;
        h.status = ST_OK;
        if (s < NSENS) begin
            if (fill[s] >= WIN) begin
                old = ring[s][slot[s]];
                run_sum[s] -= old;
                run_sq[s] -= old * old;
            end else begin
                fill[s]++;
            end
            ring[s][slot[s]] = v;
            run_sum[s] += v;
            run_sq[s] += longint'(v) * longint'(v);
            slot[s] = (slot[s] + 1) % WIN;
            n = fill[s];
            if (n >= 2) begin
                sum = run_sum[s];
                var_n = n * run_sq[s] - sum * sum;
                nn = n * n;
                den = var_n + nn * longint'(EPS_Q24);
                q = (nn << FRAC_SH) / den;
                h.conf = (q > 65535) ? 16'hFFFF : q[15:0];
            end
            add = 0;
            if (h.conf < thr_unrel) begin
                h.status = ST_UNRELIABLE;
                add += 1;
            end
            if (h.conf < thr_fail) begin
                h.status = ST_FAILED;
                add += 2;
            end
            fail_count = (fail_count + add > 255) ? 255 : fail_count + add;
            if (fail_count >= limit) fallback_on = 1'b1;
        end
        h.total = fail_count[7:0];
        h.fallback = fallback_on;
        return h;
    endfunction

    task automatic write_reg(t_reg_idx r, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(4 * int'(r));
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_UNRELIABLE: thr_unrel = val[15:0];
            REG_FAIL:       thr_fail = val[15:0];
            REG_LIMIT:      limit = val[7:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(logic [3:0] s, logic [15:0] v);
        int gap;
        gap = in_random ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12)) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sensor_index <= s;
        i_sample <= v;
        do @(posedge i_clk); while (o_in_stall);
        expected_health.insert(expected_health.size(), predict_health(s, v));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_health.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Receiver stall generator.
    initial begin
        int hold;
        forever begin
            if (long_hold > 0) begin
                i_out_stall <= 1'b1;
                @(posedge i_clk);
                long_hold--;
            end else if (out_random) begin
                hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
                if (hold > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                do @(posedge i_clk); while (!o_out_valid && long_hold == 0);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_health e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_health.size() == 0) begin
                $display("%0t: unexpected result sensor %0d", $time, o_sensor_echo);
                errors++;
            end else begin
                e = expected_health.pop_front();
                if (e.sensor !== o_sensor_echo || e.conf !== o_confidence
                    || e.status !== t_status'(o_status) || e.total !== o_failure_total
                    || e.fallback !== o_fallback) begin
                    $display("%0t: expected s=%0d c=%0d st=%0d t=%0d f=%0d, got s=%0d c=%0d st=%0d t=%0d f=%0d",
                             $time, e.sensor, e.conf, e.status, e.total, e.fallback,
                             o_sensor_echo, o_confidence, o_status, o_failure_total,
                             o_fallback);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_sample(0, 16'h0000);
        send_sample(0, 16'hFFFF);
        send_sample(0, 16'h0000);
        send_sample(0, 16'hFFFF);
        send_sample(15, 16'h1234);
        send_sample(15, 16'h1234);
        send_sample(1, 16'h5555);
        send_sample(1, 16'hAAAA);
        for (int k = 0; k < 11; k++) send_sample(2, 16'h1000 + k);
        send_sample(3, 16'h0001);
        send_sample(3, 16'h0002);
        drain();
    endtask

    task automatic test_misordered();
        write_reg(REG_UNRELIABLE, 32'd1000);
        write_reg(REG_FAIL, 32'd60000);
        write_reg(REG_LIMIT, 32'd255);
        send_sample(4, 16'h0000);
        send_sample(4, 16'h8000);
        send_sample(4, 16'h0100);
        drain();
        write_reg(REG_UNRELIABLE, 32'd65535);
        write_reg(REG_FAIL, 32'd0);
        write_reg(REG_LIMIT, 32'd1);
        send_sample(5, 16'h0010);
        send_sample(5, 16'h0012);
        drain();
    endtask

    task automatic test_random(int count);
        int burst;
        logic [3:0] s;
        logic [15:0] base;
        int left;
        left = count;
        while (left > 0) begin
            s = $urandom_range(0, 15);
            base = $urandom;
            burst = $urandom_range(1, 14);
            for (int k = 0; k < burst && left > 0; k++) begin
                case ($urandom_range(0, 3))
                    0: send_sample(s, $urandom);
                    1: send_sample(s, base ^ 16'($urandom_range(0, 3)));
                    2: send_sample(s, base + 16'($urandom_range(0, 300)));
                    default: send_sample(s, base);
                endcase
                left--;
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        long_hold = 300;
        in_random = 1'b0;
        for (int k = 0; k < 30; k++) send_sample(4'($urandom), $urandom);
        in_random = 1'b1;
        drain();
    endtask

    initial begin
        clear_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_misordered();
        write_reg(REG_UNRELIABLE, 32'd39322);
        write_reg(REG_FAIL, 32'd19661);
        write_reg(REG_LIMIT, 32'd200);
        test_random(450);
        write_reg(REG_UNRELIABLE, 32'd0);
        write_reg(REG_FAIL, 32'd65535);
        test_random(300);
        test_backpressure();
        write_reg(REG_UNRELIABLE, 32'($urandom_range(0, 65535)));
        write_reg(REG_FAIL, 32'($urandom_range(0, 65535)));
        write_reg(REG_LIMIT, 32'd255);
        test_random(300);
        out_random = 1'b0;
        test_random(250);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sensor_variance_health_monitor_top.f
design/svhm_pkg.sv
design/svhm_div.sv
design/sensor_variance_health_monitor_top.sv
test/sensor_variance_health_monitor_top_test.sv
